@@ rtl/drm_pkg.sv @@
// ----------------------------------------------------------------------------
// drm_pkg: shared definitions of the dual sine ring modulator
// Default sizes, register indexes and the command word that the controller
// sends to the datapath.
// ----------------------------------------------------------------------------
package drm_pkg;

	// Default sizes, handed down from the top level.
	localparam int DEF_SINE_TABLE_DEPTH = 1024;
	localparam int DEF_PHASE_WIDTH      = 32;
	localparam int DEF_SAMPLE_WIDTH     = 24;

	// Configuration port.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int STEP_W      = 32;
	localparam int GAIN_W      = 16;

	// Fixed widths of the oscillator and gain arithmetic.
	localparam int SINE_VAL_W = 15;  // unsigned table entry, 0 .. 32767
	localparam int SINE_W     = 16;  // one signed Q1.15 sine
	localparam int SINE_SUM_W = 17;  // sum of both sines
	localparam int MIX_W      = 34;  // combined gain (sA+sB)*wet + dry*2^15
	localparam int MUL_B_W    = 18;  // second multiplier operand

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PHASE_STEP_A = 2'd0,
		CFG_PHASE_STEP_B = 2'd1,
		CFG_WET_GAIN     = 2'd2,
		CFG_DRY_GAIN     = 2'd3
	} cfg_index_t;

	// Operand pairs of the shared multiplier.
	typedef enum logic [2:0] {
		MUL_NONE   = 3'd0,
		MUL_GAIN   = 3'd1,
		MUL_L_LOW  = 3'd2,
		MUL_L_HIGH = 3'd3,
		MUL_R_LOW  = 3'd4,
		MUL_R_HIGH = 3'd5
	} mul_sel_t;

	typedef struct packed {
		logic     capture;    // take the input frame
		logic     rd_b;       // table read for oscillator B instead of A
		logic     load_sa;    // keep sine A
		logic     load_sum;   // form sA+sB and advance both phases
		mul_sel_t mul_sel;    // multiplier operands this cycle
		logic     load_mix;   // form the combined gain
		logic     acc_init;   // accumulator = low product + rounding constant
		logic     acc_add;    // accumulator += high product * 2^16
		logic     load_left;  // saturate and keep the left result
		logic     load_out;   // saturate the right result, fill the output register
	} drm_cmd_t;

endpackage

@@ rtl/drm_if.sv @@
// ----------------------------------------------------------------------------
// drm_in_if / drm_out_if: frame channels of the dual sine ring modulator
// Valid/ready channels; a transfer happens on a rising edge with both high.
// ----------------------------------------------------------------------------
interface drm_in_if import drm_pkg::*; #(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] left_in;
	logic signed [SAMPLE_WIDTH-1:0] right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface drm_out_if import drm_pkg::*; #(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] left_out;
	logic signed [SAMPLE_WIDTH-1:0] right_out;
	logic                           clipped;

	modport source (output valid, output left_out, output right_out, output clipped,
		input ready);
	modport sink (input valid, input left_out, input right_out, input clipped,
		output ready);
endinterface

@@ rtl/drm_ctrl.sv @@
// ----------------------------------------------------------------------------
// drm_ctrl: sequencer of the dual sine ring modulator
// Steps one frame through table reads, gain and the four partial products.
// ----------------------------------------------------------------------------
module drm_ctrl import drm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output drm_cmd_t cmd
);

	typedef enum logic [10:0] {
		ST_IDLE     = 11'b000_0000_0001,
		ST_SINE_B   = 11'b000_0000_0010,
		ST_SUM      = 11'b000_0000_0100,
		ST_MUL_GAIN = 11'b000_0000_1000,
		ST_MIX      = 11'b000_0001_0000,
		ST_L_LOW    = 11'b000_0010_0000,
		ST_L_HIGH   = 11'b000_0100_0000,
		ST_R_LOW    = 11'b000_1000_0000,
		ST_R_HIGH   = 11'b001_0000_0000,
		ST_R_FINISH = 11'b010_0000_0000,
		ST_DONE     = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				// The table is read for oscillator A on the transfer edge.
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_SINE_B;
				end
			end
			ST_SINE_B: begin
				cmd.rd_b    = 1'b1;
				cmd.load_sa = 1'b1;
				state_d     = ST_SUM;
			end
			ST_SUM: begin
				cmd.load_sum = 1'b1;
				state_d      = ST_MUL_GAIN;
			end
			ST_MUL_GAIN: begin
				cmd.mul_sel = MUL_GAIN;
				state_d     = ST_MIX;
			end
			ST_MIX: begin
				cmd.load_mix = 1'b1;
				state_d      = ST_L_LOW;
			end
			ST_L_LOW: begin
				cmd.mul_sel = MUL_L_LOW;
				state_d     = ST_L_HIGH;
			end
			ST_L_HIGH: begin
				cmd.mul_sel  = MUL_L_HIGH;
				cmd.acc_init = 1'b1;
				state_d      = ST_R_LOW;
			end
			ST_R_LOW: begin
				cmd.mul_sel = MUL_R_LOW;
				cmd.acc_add = 1'b1;
				state_d     = ST_R_HIGH;
			end
			ST_R_HIGH: begin
				cmd.mul_sel   = MUL_R_HIGH;
				cmd.load_left = 1'b1;
				cmd.acc_init  = 1'b1;
				state_d       = ST_R_FINISH;
			end
			ST_R_FINISH: begin
				cmd.acc_add = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				// Wait here only while the previous result is still unclaimed.
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/drm_datapath.sv @@
// ----------------------------------------------------------------------------
// drm_datapath: oscillators, sine table and mixing arithmetic
// Holds the configuration and phase registers, the quarter-wave table and
// one shared multiplier with its accumulator.
// ----------------------------------------------------------------------------
module drm_datapath import drm_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
	parameter int PHASE_WIDTH      = DEF_PHASE_WIDTH,
	parameter int SAMPLE_WIDTH     = DEF_SAMPLE_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  drm_cmd_t                       cmd,
	input  logic                           wr_en,
	input  cfg_index_t                     wr_index,
	input  logic [CFG_DATA_W-1:0]          wr_data,
	input  logic signed [SAMPLE_WIDTH-1:0] left_in,
	input  logic signed [SAMPLE_WIDTH-1:0] right_in,
	output logic signed [SAMPLE_WIDTH-1:0] left_out,
	output logic signed [SAMPLE_WIDTH-1:0] right_out,
	output logic                           clipped
);

	localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
	localparam int OFF_W   = IDX_W - 2;
	localparam int QTR     = SINE_TABLE_DEPTH / 4;
	localparam int ROM_AW  = OFF_W + 1;
	localparam int MA_W    = (SAMPLE_WIDTH > SINE_SUM_W) ? SAMPLE_WIDTH : SINE_SUM_W;
	localparam int P_W     = MA_W + MUL_B_W;
	localparam int ACC_W   = SAMPLE_WIDTH + MIX_W;
	localparam int R_W     = ACC_W - 31;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	// Entry k is 32767*sin(pi/2*k/QTR), from a Taylor series in Q2.30.
	function automatic logic [SINE_VAL_W-1:0] sine_entry(input int k);
		longint x;
		longint x2;
		longint term;
		longint sum;
		longint v;
		x    = (HALF_PI_Q30 * longint'(k) + longint'(QTR / 2)) / QTR;
		x2   = (x * x) >>> 30;
		term = x;
		sum  = x;
		term = ((term * x2) >>> 30) / 6;
		sum  = sum - term;
		term = ((term * x2) >>> 30) / 20;
		sum  = sum + term;
		term = ((term * x2) >>> 30) / 42;
		sum  = sum - term;
		term = ((term * x2) >>> 30) / 72;
		sum  = sum + term;
		term = ((term * x2) >>> 30) / 110;
		sum  = sum - term;
		term = ((term * x2) >>> 30) / 156;
		sum  = sum + term;
		term = ((term * x2) >>> 30) / 210;
		sum  = sum - term;
		if (sum < 0) begin
			sum = 0;
		end
		v = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
		if (v > 32767) begin
			v = 32767;
		end
		return v[SINE_VAL_W-1:0];
	endfunction

	// Configuration and phase registers.
	logic [STEP_W-1:0]      step_a_q;
	logic [STEP_W-1:0]      step_b_q;
	logic [GAIN_W-1:0]      wet_q;
	logic [GAIN_W-1:0]      dry_q;
	logic [PHASE_WIDTH-1:0] phase_a_q;
	logic [PHASE_WIDTH-1:0] phase_b_q;

	// Quarter-wave table, read through a registered port.
	logic [SINE_VAL_W-1:0]  sine_rom [QTR+1];
	logic [PHASE_WIDTH-1:0] phase_sel;
	logic [1:0]             quad;
	logic [OFF_W-1:0]       off;
	logic [ROM_AW-1:0]      rom_addr;
	logic [SINE_VAL_W-1:0]  rom_q;
	logic                   neg_q;
	logic signed [SINE_W-1:0] sine_val;

	// Frame arithmetic.
	logic signed [SAMPLE_WIDTH-1:0] left_in_q;
	logic signed [SAMPLE_WIDTH-1:0] right_in_q;
	logic signed [SINE_W-1:0]       sa_q;
	logic signed [SINE_SUM_W-1:0]   sum_q;
	logic signed [MIX_W-1:0]        mix_q;
	logic signed [MA_W-1:0]         mul_a;
	logic signed [MUL_B_W-1:0]      mul_b;
	logic signed [P_W-1:0]          prod_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [R_W-1:0]          res;
	logic signed [SAMPLE_WIDTH-1:0] res_sat;
	logic                           res_clip;
	logic signed [SAMPLE_WIDTH-1:0] left_q;
	logic                           clip_l_q;

	for (genvar k = 0; k <= QTR; k++) begin : g_rom
		assign sine_rom[k] = sine_entry(k);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_a_q  <= '0;
			step_b_q  <= '0;
			wet_q     <= '0;
			dry_q     <= '0;
			phase_a_q <= '0;
			phase_b_q <= '0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					CFG_PHASE_STEP_A: step_a_q <= wr_data[STEP_W-1:0];
					CFG_PHASE_STEP_B: step_b_q <= wr_data[STEP_W-1:0];
					CFG_WET_GAIN:     wet_q    <= wr_data[GAIN_W-1:0];
					CFG_DRY_GAIN:     dry_q    <= wr_data[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load_sum) begin
				phase_a_q <= phase_a_q + PHASE_WIDTH'(step_a_q);
				phase_b_q <= phase_b_q + PHASE_WIDTH'(step_b_q);
			end
		end
	end

	// Top two index bits pick the quadrant; odd quadrants run the table backward.
	assign phase_sel = cmd.rd_b ? phase_b_q : phase_a_q;
	assign quad      = phase_sel[PHASE_WIDTH-1 -: 2];
	assign off       = phase_sel[PHASE_WIDTH-3 -: OFF_W];
	assign rom_addr  = quad[0] ? (ROM_AW'(QTR) - {1'b0, off}) : {1'b0, off};

	always_ff @(posedge clk) begin
		rom_q <= sine_rom[rom_addr];
		neg_q <= quad[1];
	end

	assign sine_val = neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			MUL_GAIN: begin
				mul_a = MA_W'(sum_q);
				mul_b = $signed({2'b00, wet_q});
			end
			MUL_L_LOW: begin
				mul_a = MA_W'(left_in_q);
				mul_b = $signed({2'b00, mix_q[15:0]});
			end
			MUL_L_HIGH: begin
				mul_a = MA_W'(left_in_q);
				mul_b = mix_q[MIX_W-1:16];
			end
			MUL_R_LOW: begin
				mul_a = MA_W'(right_in_q);
				mul_b = $signed({2'b00, mix_q[15:0]});
			end
			MUL_R_HIGH: begin
				mul_a = MA_W'(right_in_q);
				mul_b = mix_q[MIX_W-1:16];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Result is floor((in*g + 2^30) / 2^31); saturate when the top bits disagree.
	assign res      = acc_q[ACC_W-1:31];
	assign res_clip = (res[R_W-1:SAMPLE_WIDTH-1] != '0) && (res[R_W-1:SAMPLE_WIDTH-1] != '1);
	always_comb begin
		if (!res_clip) begin
			res_sat = res[SAMPLE_WIDTH-1:0];
		end else if (res[R_W-1]) begin
			res_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		end else begin
			res_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			left_in_q  <= left_in;
			right_in_q <= right_in;
		end
		if (cmd.load_sa) begin
			sa_q <= sine_val;
		end
		if (cmd.load_sum) begin
			sum_q <= SINE_SUM_W'(sa_q) + SINE_SUM_W'(sine_val);
		end
		prod_q <= mul_a * mul_b;
		if (cmd.load_mix) begin
			mix_q <= MIX_W'(prod_q) + $signed(MIX_W'({dry_q, 15'b0}));
		end
		if (cmd.acc_init) begin
			acc_q <= ACC_W'(prod_q) + $signed(ACC_W'(64'd1 << 30));
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + (ACC_W'(prod_q) <<< 16);
		end
		if (cmd.load_left) begin
			left_q   <= res_sat;
			clip_l_q <= res_clip;
		end
		if (cmd.load_out) begin
			left_out  <= left_q;
			right_out <= res_sat;
			clipped   <= clip_l_q | res_clip;
		end
	end

endmodule

@@ rtl/dual_sine_ring_modulator.sv @@
// ----------------------------------------------------------------------------
// dual_sine_ring_modulator: stereo ring modulator with two sine oscillators
// Each frame is multiplied by the sum of two table sines, mixed wet and dry,
// then rounded and saturated.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload                          transfer when
//   samples   in         left_in, right_in                valid & ready
//   results   out        left_out, right_out, clipped     valid & ready
//   wr_*      in         wr_index, wr_data                wr_en
//
// A frame runs from its transfer to its result in the output register, led
// by the sequencer that runs one shared multiplier through the gain product
// and four partial products, after two reads of the sine table through its
// single registered port. Input is ready in the cycle after the result loads.
// Reset clears the phases, the configuration and the sequencer at once.
// A result that is not taken holds the sequencer in its last step only once
// a second result is ready; input is taken again after that.
//
module dual_sine_ring_modulator import drm_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
	parameter int PHASE_WIDTH      = DEF_PHASE_WIDTH,
	parameter int SAMPLE_WIDTH     = DEF_SAMPLE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	drm_in_if.sink                 samples,
	drm_out_if.source              results,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data
);

	// Command word from the sequencer to the datapath.
	drm_cmd_t cmd;

	// The sequencer owns both handshakes; the datapath owns every payload.
	drm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd)
	);

	// Configuration writes go straight to the datapath registers; the user must
	// issue them only while no frame is in flight; the block does not enforce it.
	drm_datapath #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.PHASE_WIDTH      (PHASE_WIDTH),
		.SAMPLE_WIDTH     (SAMPLE_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.wr_en     (wr_en),
		.wr_index  (cfg_index_t'(wr_index)),
		.wr_data   (wr_data),
		.left_in   (samples.left_in),
		.right_in  (samples.right_in),
		.left_out  (results.left_out),
		.right_out (results.right_out),
		.clipped   (results.clipped)
	);

endmodule
